>>> rtl/core/spf_pkg.sv
// Shared types and constants for the smallest-prime-factor factorizer.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package spf_pkg;

   localparam int unsigned WORD_W = 16;

   typedef enum logic [1:0] {
      KIND_UNIT,
      KIND_OVER,
      KIND_TABLE
   } item_kind_type;

   typedef struct packed {
      item_kind_type     kind;
      logic [WORD_W-1:0] value;
   } queue_entry_type;

   typedef struct packed {
      logic              en;
      logic [WORD_W-1:0] addr;
   } table_rd_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [1:0] {
      FILL_INIT,
      FILL_SIEVE,
      FILL_DONE
   } fill_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WAIT,
      BK_DIV
   } back_state_type;

endpackage

>>> rtl/core/spf_table.sv
// Smallest-prime-factor table memory and the sieve that fills it after reset.
// Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_table #(
   parameter int unsigned LIMIT = 65535
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spf_pkg::table_rd_type        rd,
   output logic [spf_pkg::WORD_W-1:0]   rd_data,
   output logic                         ready
);

   localparam logic [16:0] LIM17 = 17'(LIMIT);

   logic [spf_pkg::WORD_W-1:0] mem [0:65535];
   logic [spf_pkg::WORD_W-1:0] rd_data_ff;

   spf_pkg::fill_state_type state_ff, state_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  i_ff, i_in;
   logic [16:0] j_ff, j_in;
   logic [7:0]  i_dec;
   logic        we;
   logic [15:0] wa;
   logic [15:0] wd;

   assign i_dec = i_ff - 8'd1;

   // Divisors run downward and write unconditionally: the smallest one lands last.
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      we       = 1'b0;
      wa       = addr_ff;
      wd       = 16'd0;
      unique case (state_ff)
         spf_pkg::FILL_INIT: begin
            we      = 1'b1;
            wd      = (addr_ff >= 16'd2 && {1'b0, addr_ff} <= LIM17) ? addr_ff : 16'd0;
            addr_in = addr_ff + 16'd1;
            if (addr_ff == 16'hFFFF) begin
               state_in = spf_pkg::FILL_SIEVE;
               i_in     = 8'd255;
               j_in     = 17'd65025;
            end
         end
         spf_pkg::FILL_SIEVE: begin
            if (j_ff > LIM17) begin
               if (i_ff == 8'd2) begin
                  state_in = spf_pkg::FILL_DONE;
               end else begin
                  i_in = i_dec;
                  j_in = {9'd0, i_dec} * {9'd0, i_dec};
               end
            end else begin
               we   = 1'b1;
               wa   = j_ff[15:0];
               wd   = {8'd0, i_ff};
               j_in = j_ff + {9'd0, i_ff};
            end
         end
         spf_pkg::FILL_DONE: begin
         end
         default: state_in = spf_pkg::FILL_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spf_pkg::FILL_INIT;
         addr_ff  <= 16'd0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
   end

   always_ff @(posedge clock) begin
      if (rd.en) rd_data_ff <= mem[rd.addr];
   end

   assign rd_data = rd_data_ff;
   assign ready   = (state_ff == spf_pkg::FILL_DONE);

endmodule

>>> rtl/core/spf_front.sv
// Front end: accepts request transactions, classifies them, holds a two-entry queue.
// Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_front #(
   parameter int unsigned LIMIT = 65535
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          table_ready,
   input  logic                          start,
   input  logic [spf_pkg::WORD_W-1:0]    req_value,
   output logic                          busy,
   input  logic                          pop,
   output logic                          head_valid,
   output spf_pkg::queue_entry_type      head
);

   localparam logic [16:0] LIM17 = 17'(LIMIT);

   spf_pkg::queue_entry_type ent_ff [0:1];
   spf_pkg::queue_entry_type ent_new;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop_ok;

   assign busy   = !table_ready || (count_ff == 2'd2);
   assign push   = start && !busy;
   assign pop_ok = pop && (count_ff != 2'd0);

   always_comb begin
      ent_new.value = req_value;
      if (req_value < 16'd2)               ent_new.kind = spf_pkg::KIND_UNIT;
      else if ({1'b0, req_value} > LIM17)  ent_new.kind = spf_pkg::KIND_OVER;
      else                                 ent_new.kind = spf_pkg::KIND_TABLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push)   wr_ptr_ff <= ~wr_ptr_ff;
         if (pop_ok) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop_ok};
      end
      if (push) ent_ff[wr_ptr_ff] <= ent_new;
   end

   assign head_valid = (count_ff != 2'd0);
   assign head       = ent_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop_ok) |=> count_ff == 2'd2) else $error("full queue lost entry");
   a_no_accept_cold: assert property (@(posedge clock) disable iff (reset)
      !table_ready |-> !push) else $error("accepted before table fill");

endmodule

>>> rtl/core/spf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  spf_pkg::div_req_type        req,
   output logic                        done,
   output logic [spf_pkg::WORD_W-1:0]  quotient
);

   logic [15:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;

   assign shifted = {rem_ff[15:0], quo_ff[15]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = 17'd0;
         cnt_in = 5'd16;
      end else if (cnt_ff != 5'd0) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in  = cnt_ff - 5'd1;
         done_in = (cnt_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 5'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (req.start) dvs_ff <= req.divisor;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/spf_back.sv
// Back end: walks the table and divider for each queued value and drives results.
// Depends on spf_pkg and spf_div.
`timescale 1ns / 1ps

module spf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  spf_pkg::queue_entry_type     head,
   output logic                         pop,
   output spf_pkg::table_rd_type        rd,
   input  logic [spf_pkg::WORD_W-1:0]   rd_data,
   output logic                         rsp_valid,
   output logic [spf_pkg::WORD_W-1:0]   rsp_factor,
   output logic                         rsp_last,
   output logic                         rsp_value_is_prime
);

   spf_pkg::back_state_type state_ff, state_in;
   spf_pkg::div_req_type    div_req;
   logic [15:0] value_ff, value_in;
   logic [15:0] n_ff, n_in;
   logic [15:0] p_ff, p_in;
   logic [3:0]  k_ff, k_in;
   logic        prime_ff, prime_in;
   logic        div_done;
   logic [15:0] quotient;
   logic        emit;
   logic [15:0] emit_factor;
   logic        emit_last, emit_prime, fin;
   logic        rsp_valid_ff;
   logic [15:0] rsp_factor_ff;
   logic        rsp_last_ff, rsp_prime_ff;

   spf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   assign fin = (quotient == 16'd1) || (k_ff == 4'd15);

   always_comb begin
      state_in         = state_ff;
      value_in         = value_ff;
      n_in             = n_ff;
      p_in             = p_ff;
      k_in             = k_ff;
      prime_in         = prime_ff;
      pop              = 1'b0;
      rd.en            = 1'b0;
      rd.addr          = n_ff;
      div_req.start    = 1'b0;
      div_req.dividend = n_ff;
      div_req.divisor  = rd_data;
      emit             = 1'b0;
      emit_factor      = 16'd1;
      emit_last        = 1'b1;
      emit_prime       = 1'b0;
      unique case (state_ff)
         spf_pkg::BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               unique case (head.kind)
                  spf_pkg::KIND_UNIT: emit = 1'b1;
                  spf_pkg::KIND_OVER: begin
                     emit        = 1'b1;
                     emit_factor = head.value;
                  end
                  default: begin
                     value_in = head.value;
                     n_in     = head.value;
                     k_in     = 4'd0;
                     state_in = spf_pkg::BK_READ;
                  end
               endcase
            end
         end
         spf_pkg::BK_READ: begin
            rd.en    = 1'b1;
            state_in = spf_pkg::BK_WAIT;
         end
         spf_pkg::BK_WAIT: begin
            // the first lookup is at the value itself and settles primality
            if (k_ff == 4'd0) prime_in = (rd_data == value_ff);
            if (rd_data < 16'd2) begin
               emit        = 1'b1;
               emit_factor = value_ff;
               emit_prime  = (k_ff == 4'd0) ? (rd_data == value_ff) : prime_ff;
               state_in    = spf_pkg::BK_IDLE;
            end else begin
               p_in          = rd_data;
               div_req.start = 1'b1;
               state_in      = spf_pkg::BK_DIV;
            end
         end
         spf_pkg::BK_DIV: begin
            if (div_done) begin
               emit        = 1'b1;
               emit_factor = p_ff;
               emit_last   = fin;
               emit_prime  = prime_ff;
               k_in        = k_ff + 4'd1;
               n_in        = quotient;
               state_in    = fin ? spf_pkg::BK_IDLE : spf_pkg::BK_READ;
            end
         end
         default: state_in = spf_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spf_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
      end
      value_ff      <= value_in;
      n_ff          <= n_in;
      p_ff          <= p_in;
      k_ff          <= k_in;
      prime_ff      <= prime_in;
      rsp_factor_ff <= emit_factor;
      rsp_last_ff   <= emit_last;
      rsp_prime_ff  <= emit_prime;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_factor         = rsp_factor_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_value_is_prime = rsp_prime_ff;

   a_div_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spf_pkg::BK_DIV && div_done) |=> rsp_valid_ff)
      else $error("divider result not sent");
   a_mid_factor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> rsp_factor_ff >= 16'd2)
      else $error("bad factor inside run");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == spf_pkg::BK_IDLE) else $error("pop while working");

endmodule

>>> rtl/core/sieve_prime_factorizer.sv
// Prime factorizer over a smallest-prime-factor table. Reset is synchronous:
// after it the table fill runs an init sweep over every address plus one write
// per sieve multiple, with busy high. Per value the back end pops it, then for
// each factor reads the table, takes the lookup and runs the divide, at most 15
// factors; 0, 1 and out-of-range values are answered straight from the pop with
// a single result. Results are one-cycle rsp_valid strobes; no stall.
`timescale 1ns / 1ps

module sieve_prime_factorizer #(
   parameter int unsigned MAX_VALUE = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   output logic [15:0] rsp_factor,
   output logic        rsp_last,
   output logic        rsp_value_is_prime
);

   localparam int unsigned LIMIT = (MAX_VALUE > 65535) ? 65535 : MAX_VALUE;

   logic                     table_ready;
   logic                     head_valid;
   logic                     pop;
   spf_pkg::queue_entry_type head;
   spf_pkg::table_rd_type    rd;
   logic [15:0]              rd_data;

   spf_table #(.LIMIT(LIMIT)) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .rd_data (rd_data),
      .ready   (table_ready)
   );

   spf_front #(.LIMIT(LIMIT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .table_ready (table_ready),
      .start       (start),
      .req_value   (req_value),
      .busy        (busy),
      .pop         (pop),
      .head_valid  (head_valid),
      .head        (head)
   );

   spf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head               (head),
      .pop                (pop),
      .rd                 (rd),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_factor         (rsp_factor),
      .rsp_last           (rsp_last),
      .rsp_value_is_prime (rsp_value_is_prime)
   );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for sieve_prime_factorizer: waits out the table fill,
// then drives a directed table and random values, checking each factor strobe.
// Depends on rtl/core/spf_pkg.sv and rtl/core/sieve_prime_factorizer.sv.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned LIMIT_VALUE = 65535;
   localparam int unsigned FACTOR_CAP = 16;
   localparam longint MAX_CYCLES = 64'd3_000_000;
   localparam int N_RANDOM = 280;
   localparam int N_DIRECTED = 16;

   typedef struct packed {
      logic [15:0] factor;
      logic        last;
      logic        prime_flag;
   } factor_rec_t;

   typedef struct {
      logic [15:0] value;
      bit          typed;
      factor_rec_t rec;
   } stim_row_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_value;
   logic        rsp_valid;
   logic [15:0] rsp_factor;
   logic        rsp_last;
   logic        rsp_value_is_prime;

   logic [15:0] spf_model [0:65535];
   factor_rec_t pending_factors [$];
   int          mismatches;
   longint      cycle_count;
   int          idle_pct;

   sieve_prime_factorizer #(.MAX_VALUE(LIMIT_VALUE)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_factor(rsp_factor),
      .rsp_last(rsp_last),
      .rsp_value_is_prime(rsp_value_is_prime)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               want);
      mismatches++;
   endtask

   function automatic void build_spf_model();
      int unsigned i;
      int unsigned j;
      for (i = 0; i < 65536; i++)
         spf_model[i] = (i >= 2 && i <= LIMIT_VALUE) ? 16'(i) : 16'd0;
      for (i = 2; i * i <= LIMIT_VALUE; i++) begin
         if (spf_model[i] == 16'(i)) begin
            for (j = i * i; j <= LIMIT_VALUE; j += i)
               if (spf_model[j] == 16'(j)) spf_model[j] = 16'(i);
         end
      end
   endfunction

   // Push the expected factor run for one accepted value.
   function automatic void predict_factors(input logic [15:0] v);
      int unsigned n;
      int unsigned p;
      int          k;
      logic        prime;
      k = 0;
      if (v < 2) begin
         pending_factors.push_back('{16'd1, 1'b1, 1'b0});
         return;
      end
      if (v > LIMIT_VALUE) begin
         pending_factors.push_back('{v, 1'b1, 1'b0});
         return;
      end
      prime = (spf_model[v] == v);
      n = v;
      while (n > 1 && k < FACTOR_CAP) begin
         p = spf_model[n[15:0]];
         if (p < 2) break;
         pending_factors.push_back('{16'(p), 1'b0, prime});
         k++;
         n = n / p;
      end
      if (k == 0) pending_factors.push_back('{v, 1'b1, prime});
      else pending_factors[pending_factors.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      factor_rec_t want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_factors.size() == 0) begin
            report_mismatch("unexpected factor", rsp_factor, 0);
         end else begin
            want = pending_factors.pop_front();
            if (rsp_factor !== want.factor) report_mismatch("factor", rsp_factor, want.factor);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            if (rsp_value_is_prime !== want.prime_flag)
               report_mismatch("value_is_prime", rsp_value_is_prime, want.prime_flag);
         end
      end
      if (cycle_count > MAX_CYCLES) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Present one transaction at the falling edge, hold until accepted.
   task automatic send_value(input logic [15:0] v);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) @(negedge clock);
      end
      start <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_factors(v);
      @(negedge clock);
   endtask

   task automatic drain_factors();
      start <= 1'b0;
      while (pending_factors.size() != 0) @(negedge clock);
   endtask

   stim_row_t directed_rows [N_DIRECTED];

   initial begin
      int i;
      int phase;
      logic [15:0] v;
      factor_rec_t got;
      mismatches = 0;
      cycle_count = 0;
      idle_pct = 0;
      start = 1'b0;
      req_value = '0;
      reset = 1'b1;
      build_spf_model();
      directed_rows = '{
         '{16'd0, 1'b1, '{16'd1, 1'b1, 1'b0}},
         '{16'd1, 1'b1, '{16'd1, 1'b1, 1'b0}},
         '{16'd2, 1'b1, '{16'd2, 1'b1, 1'b1}},
         '{16'd3, 1'b1, '{16'd3, 1'b1, 1'b1}},
         '{16'd65521, 1'b1, '{16'd65521, 1'b1, 1'b1}},
         '{16'd65535, 1'b0, '0},
         '{16'd32768, 1'b0, '0},
         '{16'd65534, 1'b0, '0},
         '{16'd4, 1'b0, '0},
         '{16'd49152, 1'b0, '0},
         '{16'd65025, 1'b0, '0},
         '{16'd30030, 1'b0, '0},
         '{16'd43690, 1'b0, '0},
         '{16'd21845, 1'b0, '0},
         '{16'd65519, 1'b0, '0},
         '{16'd32767, 1'b0, '0}
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      for (i = 0; i < N_DIRECTED; i++) begin
         send_value(directed_rows[i].value);
         if (directed_rows[i].typed) begin
            got = pending_factors[pending_factors.size() - 1];
            if (got !== directed_rows[i].rec)
               report_mismatch("directed prediction", got.factor,
                               directed_rows[i].rec.factor);
         end
      end
      // Hold off until all outstanding factors have arrived.
      drain_factors();

      for (i = 0; i < N_RANDOM; i++) begin
         phase = (i * 4) / N_RANDOM;
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 82;
            2: idle_pct = 34;
            default: idle_pct = (i % 40 < 20) ? 0 : 82;
         endcase
         case ($urandom_range(3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(255));
            2: v = 16'(1 << $urandom_range(15)) * 16'($urandom_range(3) + 1);
            default: v = 16'($urandom_range(65535, 32768));
         endcase
         send_value(v);
      end

      drain_factors();
      repeat (400) @(posedge clock);
      if (mismatches == 0 && pending_factors.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
